/* design/hrbw_pkg.sv */
`default_nettype none

package hrbw_pkg;

  // counter width default and the count limit for plain bit writes
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int MAX_PUT_BITS    = 24;

  // result buffer for one item
  localparam int RES_DEPTH = 13;
  localparam int RES_IDX_W = $clog2(RES_DEPTH);

  // width of the reported totals and of the buffer size register
  localparam int TOTAL_W     = 24;
  localparam int ROOM_MARGIN = 5;

  localparam logic [TOTAL_W-1:0] BUF_SIZE_RESET = 24'hFFFFFF;
  localparam logic [7:0]         ESC_BYTE       = 8'h03;

  typedef enum logic [2:0] {
    CMD_HEADER  = 3'd0,
    CMD_PAYLOAD = 3'd1,
    CMD_UE      = 3'd2,
    CMD_SE      = 3'd3,
    CMD_TRAIL   = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_code_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic step;
    logic emit_adv;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;
    logic go_step;
    logic scan_found;
    logic step_done;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/hrbw_ctrl.sv */
`default_nettype none

module hrbw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire hrbw_pkg::dp_status_t st,
  output hrbw_pkg::dp_cmd_t        cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_STEP = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        if (st.go_scan) begin
          state_nxt = ST_SCAN;
        end else if (st.go_step) begin
          state_nxt = ST_STEP;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_found) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (st.step_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          cmd.emit_adv = 1'b1;
          if (st.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign out_valid = (state_r == ST_EMIT);

endmodule

`default_nettype wire

/* design/hrbw_datapath.sv */
`default_nettype none

module hrbw_datapath #(
  parameter int COUNT_WIDTH = hrbw_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hrbw_pkg::dp_cmd_t             cmd,
  output hrbw_pkg::dp_status_t               st,
  input  wire logic [2:0]                    in_command,
  input  wire logic [31:0]                   in_value,
  input  wire logic [4:0]                    in_bit_count,
  input  wire logic [hrbw_pkg::TOTAL_W-1:0]  buf_size,
  output logic                               out_byte_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_is_escape,
  output logic                               out_last,
  output logic [hrbw_pkg::TOTAL_W-1:0]       out_byte_total,
  output logic [hrbw_pkg::TOTAL_W-1:0]       out_escape_total,
  output logic                               out_overflow_flag,
  output logic [2:0]                         out_pending_count
);

  localparam int EXT_W = (COUNT_WIDTH > hrbw_pkg::TOTAL_W) ? COUNT_WIDTH : hrbw_pkg::TOTAL_W;
  localparam int CMP_W = EXT_W + 1;
  localparam int IDX_W = hrbw_pkg::RES_IDX_W;

  // architectural state
  logic [7:0]             acc_r;
  logic [2:0]             pend_r;
  logic [1:0]             zrun_r;
  logic [COUNT_WIDTH-1:0] bytes_r;
  logic [COUNT_WIDTH-1:0] escs_r;
  logic                   ovf_r;

  // per item working registers
  logic [2:0]  opc_r;
  logic [31:0] val_r;
  logic [4:0]  cnt_r;
  logic [32:0] src_r;
  logic [6:0]  rem_r;
  logic        payload_r;
  logic        escdone_r;
  logic [7:0]  sacc_r;
  logic [2:0]  spend_r;
  logic [1:0]  scan_r;

  // result buffer
  logic [8:0]       ent_r [hrbw_pkg::RES_DEPTH];
  logic [IDX_W-1:0] wr_r;
  logic [IDX_W-1:0] rd_r;

  // buffer room check
  logic [EXT_W-1:0] bytes_ext, escs_ext;
  logic             room_fail;

  assign bytes_ext = EXT_W'(bytes_r);
  assign escs_ext  = EXT_W'(escs_r);
  assign room_fail = (CMP_W'(bytes_r) + CMP_W'(hrbw_pkg::ROOM_MARGIN)) > CMP_W'(buf_size);

  // exp-golomb code number plus one
  logic [32:0] neg_mag, se_cn, code_num, golomb_n;

  always_comb begin
    neg_mag = {1'b0, ~val_r} + 33'd1;
    if (val_r[31]) begin
      se_cn = {neg_mag[31:0], 1'b0};
    end else if (val_r == 32'd0) begin
      se_cn = '0;
    end else begin
      se_cn = {val_r, 1'b0} - 33'd1;
    end
    code_num = (opc_r == hrbw_pkg::CMD_SE) ? se_cn : {1'b0, val_r};
    golomb_n = code_num + 33'd1;
  end

  // leading one search, one 11 bit slice per cycle from the top
  logic [10:0] chunk;
  logic [5:0]  base;
  logic [3:0]  pos;
  logic [5:0]  code_len;
  logic [6:0]  scan_rem;

  always_comb begin
    case (scan_r)
      2'd0: begin
        chunk = src_r[32:22];
        base  = 6'd22;
      end
      2'd1: begin
        chunk = src_r[21:11];
        base  = 6'd11;
      end
      default: begin
        chunk = src_r[10:0];
        base  = 6'd0;
      end
    endcase
    pos = '0;
    for (int i = 0; i < 11; i++) begin
      if (chunk[i]) begin
        pos = 4'(i);
      end
    end
    code_len = base + 6'(pos) + 6'd1;
    scan_rem = {code_len, 1'b0} - 7'd1;
  end

  // one byte slot per step
  logic [3:0]  room4, k4;
  logic [6:0]  s7;
  logic [40:0] src_sh;
  logic [7:0]  mask, bits, merged;
  logic [2:0]  lsh;
  logic        full, chk, do_ovf, do_esc, do_byte;

  always_comb begin
    room4   = 4'd8 - {1'b0, pend_r};
    k4      = (rem_r < {3'b0, room4}) ? rem_r[3:0] : room4;
    s7      = rem_r - {3'b0, k4};
    src_sh  = {8'b0, src_r} >> s7;
    mask    = 8'((9'd1 << k4) - 9'd1);
    bits    = src_sh[7:0] & mask;
    lsh     = 3'(room4 - k4);
    merged  = acc_r | (bits << lsh);
    full    = (k4 == room4);
    chk     = payload_r && !escdone_r;
    do_ovf  = full && chk && room_fail;
    do_esc  = full && chk && !room_fail && (zrun_r == 2'd2) && (merged < 8'd4);
    do_byte = full && !do_ovf && !do_esc;
  end

  // status to the controller
  logic has_res;
  assign has_res = (wr_r != '0);

  always_comb begin
    st            = '0;
    st.scan_found = (chunk != '0) || (scan_r == 2'd2);
    st.step_done  = !full || do_ovf || (do_byte && (s7 == 7'd0));
    st.emit_last  = !has_res || (rd_r == (wr_r - IDX_W'(1)));
    case (opc_r)
      hrbw_pkg::CMD_HEADER:  st.go_step = !room_fail && (cnt_r != 5'd0);
      hrbw_pkg::CMD_PAYLOAD: st.go_step = (cnt_r != 5'd0);
      hrbw_pkg::CMD_UE:      st.go_scan = 1'b1;
      hrbw_pkg::CMD_SE:      st.go_scan = 1'b1;
      hrbw_pkg::CMD_TRAIL:   st.go_step = 1'b1;
      default:               st.go_step = 1'b0;
    endcase
  end

  logic       ent_we;
  logic [8:0] ent_din;
  assign ent_we  = cmd.step && (do_esc || do_byte) && (wr_r < IDX_W'(hrbw_pkg::RES_DEPTH));
  assign ent_din = do_esc ? {1'b1, hrbw_pkg::ESC_BYTE} : {1'b0, merged};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      pend_r    <= '0;
      zrun_r    <= '0;
      bytes_r   <= '0;
      escs_r    <= '0;
      ovf_r     <= 1'b0;
      escdone_r <= 1'b0;
      scan_r    <= '0;
      wr_r      <= '0;
      rd_r      <= '0;
    end else begin
      if (cmd.load) begin
        wr_r      <= '0;
        rd_r      <= '0;
        escdone_r <= 1'b0;
        scan_r    <= '0;
      end
      if (cmd.prep) begin
        case (opc_r)
          hrbw_pkg::CMD_HEADER: begin
            if (room_fail) begin
              ovf_r <= 1'b1;
            end
          end
          hrbw_pkg::CMD_RESTART: begin
            acc_r   <= '0;
            pend_r  <= '0;
            zrun_r  <= '0;
            bytes_r <= '0;
            escs_r  <= '0;
            ovf_r   <= (buf_size < hrbw_pkg::TOTAL_W'(hrbw_pkg::ROOM_MARGIN));
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan && !st.scan_found) begin
        scan_r <= scan_r + 2'd1;
      end
      if (cmd.step) begin
        if (!full) begin
          // item ends inside the current byte
          acc_r  <= merged;
          pend_r <= pend_r + 3'(k4);
        end else if (do_ovf) begin
          // abandon: accumulator back to item start
          ovf_r  <= 1'b1;
          acc_r  <= sacc_r;
          pend_r <= spend_r;
        end else if (do_esc) begin
          bytes_r   <= bytes_r + 1'b1;
          escs_r    <= escs_r + 1'b1;
          zrun_r    <= '0;
          escdone_r <= 1'b1;
        end else begin
          bytes_r   <= bytes_r + 1'b1;
          acc_r     <= '0;
          pend_r    <= '0;
          escdone_r <= 1'b0;
          if (payload_r) begin
            zrun_r <= (merged == 8'd0) ? zrun_r + 2'd1 : 2'd0;
          end
        end
      end
      if (ent_we) begin
        wr_r <= wr_r + IDX_W'(1);
      end
      if (cmd.emit_adv) begin
        rd_r <= rd_r + IDX_W'(1);
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opc_r   <= in_command;
      val_r   <= in_value;
      cnt_r   <= (in_bit_count > 5'(hrbw_pkg::MAX_PUT_BITS)) ?
                 5'(hrbw_pkg::MAX_PUT_BITS) : in_bit_count;
      sacc_r  <= acc_r;
      spend_r <= pend_r;
    end
    if (cmd.prep) begin
      case (opc_r)
        hrbw_pkg::CMD_HEADER: begin
          src_r     <= {1'b0, val_r};
          rem_r     <= 7'(cnt_r);
          payload_r <= 1'b0;
        end
        hrbw_pkg::CMD_PAYLOAD: begin
          src_r     <= {1'b0, val_r};
          rem_r     <= 7'(cnt_r);
          payload_r <= 1'b1;
        end
        hrbw_pkg::CMD_UE, hrbw_pkg::CMD_SE: begin
          src_r     <= golomb_n;
          payload_r <= 1'b1;
        end
        hrbw_pkg::CMD_TRAIL: begin
          // stop bit then zeros to the byte boundary
          src_r     <= 33'(8'h80 >> pend_r);
          rem_r     <= 7'(4'd8 - {1'b0, pend_r});
          payload_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.scan && st.scan_found) begin
      rem_r <= scan_rem;
    end
    if (cmd.step && do_byte) begin
      rem_r <= s7;
    end
    if (ent_we) begin
      ent_r[wr_r] <= ent_din;
    end
  end

  // result words
  assign out_byte_valid    = has_res;
  assign out_byte          = has_res ? ent_r[rd_r][7:0] : 8'd0;
  assign out_is_escape     = has_res && ent_r[rd_r][8];
  assign out_last          = st.emit_last;
  assign out_byte_total    = bytes_ext[hrbw_pkg::TOTAL_W-1:0];
  assign out_escape_total  = escs_ext[hrbw_pkg::TOTAL_W-1:0];
  assign out_overflow_flag = ovf_r;
  assign out_pending_count = pend_r;

endmodule

`default_nettype wire

/* design/h264_rbsp_bit_writer_unit.sv */
// H.264 RBSP bit writer: packs header bits, payload bits, ue(v), se(v) and
// trailing bits MSB first into stream bytes, with 0x03 emulation prevention
// on payload bytes.
// input channel: in_valid / in_stall with in_command, in_value, in_bit_count.
//   one word is taken at an edge with in_valid high and in_stall low. the
//   unit works on one word at a time, in_stall stays high until the last
//   result word of that item has been taken.
// result channel: out_valid / out_stall, one result word per stream byte
//   (escapes included, at most 13), or one status word when no byte is
//   completed. out_last marks the final word of the item. totals, flag and
//   pending count show the state at the end of the item.
// sequence: the word is taken, a prepare step follows, then a leading-one
//   search for ue/se (11 bits a cycle), then, unless the item writes no
//   bits, the byte packer, one step per stream byte or escape, and last the
//   result words in order.
// a stalled result word holds steady until out_stall drops.
// reset (rst_n low, synchronous) clears accumulator, counters and overflow
// flag and sets buffer_size to 16777215.
// config: APB register buffer_size at address 0, writes take effect at once.
`default_nettype none

module h264_rbsp_bit_writer_unit #(
  parameter int COUNT_WIDTH = hrbw_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_command,
  input  wire logic [31:0]                   in_value,
  input  wire logic [4:0]                    in_bit_count,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_byte_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_is_escape,
  output logic                               out_last,
  output logic [hrbw_pkg::TOTAL_W-1:0]       out_byte_total,
  output logic [hrbw_pkg::TOTAL_W-1:0]       out_escape_total,
  output logic                               out_overflow_flag,
  output logic [2:0]                         out_pending_count,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // register index sits above the byte offset
  localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

  logic [hrbw_pkg::TOTAL_W-1:0] buf_size_r;
  logic                         reg_sel;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2:2] == REG_BUFFER_SIZE);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= hrbw_pkg::BUF_SIZE_RESET;
    end else if (cfg_wr && reg_sel) begin
      buf_size_r <= pwdata[hrbw_pkg::TOTAL_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(buf_size_r) : 32'd0;

  // sequencer and byte packer
  hrbw_pkg::dp_cmd_t    dp_cmd;
  hrbw_pkg::dp_status_t dp_st;

  hrbw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (dp_st),
    .cmd       (dp_cmd)
  );

  hrbw_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .st                (dp_st),
    .in_command        (in_command),
    .in_value          (in_value),
    .in_bit_count      (in_bit_count),
    .buf_size          (buf_size_r),
    .out_byte_valid    (out_byte_valid),
    .out_byte          (out_byte),
    .out_is_escape     (out_is_escape),
    .out_last          (out_last),
    .out_byte_total    (out_byte_total),
    .out_escape_total  (out_escape_total),
    .out_overflow_flag (out_overflow_flag),
    .out_pending_count (out_pending_count)
  );

endmodule

`default_nettype wire

/* design/hrbw_checker.sv */
`default_nettype none

module hrbw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_byte_valid,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_escape,
  input wire logic       out_last
);

  // held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result word changed while stalled");

  // a taken word is followed by a prepare cycle with no result
  a_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("result or accept right after taking a word");

  // no new word while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  // status word is alone and empty
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_byte == 8'd0) && !out_is_escape)
    else $error("bad status word");

  // escapes carry the escape byte
  a_escape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_escape |-> out_byte_valid && (out_byte == hrbw_pkg::ESC_BYTE)
    && !out_last)
    else $error("bad escape word");

endmodule

bind h264_rbsp_bit_writer_unit hrbw_checker u_hrbw_checker (.*);

`default_nettype wire
